@@ sv/tcvc_pkg.sv @@
// Shared constants and types for the tetrahedron common-vertex comparator.
package tcvc_pkg;

  localparam int NUM_VERT       = 4;
  localparam int FIELD_BITS     = 24;
  localparam int COUNT_BITS     = 5;
  localparam int NA_BITS        = 3;
  localparam int SLOT_BITS      = 2;
  localparam int INDEX_BITS_DEF = 24;

  // Match summary handed from the comparator array to the reorder network.
  typedef struct packed {
    logic [NUM_VERT-1:0] ca;        // A slot equals some B slot
    logic [NUM_VERT-1:0] cb;        // B slot equals some A slot
    logic [NA_BITS-1:0]  na;        // number of flagged A slots
    logic                mismatch;  // flagged A and B slot counts differ
  } tcvc_match_t;

endpackage

@@ sv/tcvc_match.sv @@
// Sixteen index comparators, pair count and common-slot flags.
module tcvc_match #(
  parameter int IDX_W = tcvc_pkg::INDEX_BITS_DEF
) (
  input  logic                            same_mesh_i,
  input  logic [IDX_W-1:0]                a_i [tcvc_pkg::NUM_VERT],
  input  logic [IDX_W-1:0]                b_i [tcvc_pkg::NUM_VERT],
  output logic [tcvc_pkg::COUNT_BITS-1:0] count_o,
  output tcvc_pkg::tcvc_match_t           match_o
);

  logic [tcvc_pkg::NUM_VERT-1:0] eq [tcvc_pkg::NUM_VERT];
  logic [tcvc_pkg::NA_BITS-1:0]  nb;

  always_comb begin
    for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
      for (int j = 0; j < tcvc_pkg::NUM_VERT; j++) begin
        eq[i][j] = same_mesh_i && (a_i[i] == b_i[j]);
      end
    end
  end

  always_comb begin
    count_o     = '0;
    match_o.na  = '0;
    nb          = '0;
    for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
      match_o.ca[i] = |eq[i];
      match_o.cb[i] = 1'b0;
      for (int j = 0; j < tcvc_pkg::NUM_VERT; j++) begin
        match_o.cb[i] = match_o.cb[i] | eq[j][i];
        count_o       = count_o + tcvc_pkg::COUNT_BITS'(eq[i][j]);
      end
    end
    for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
      match_o.na = match_o.na + tcvc_pkg::NA_BITS'(match_o.ca[i]);
      nb         = nb + tcvc_pkg::NA_BITS'(match_o.cb[i]);
    end
    match_o.mismatch = (match_o.na != nb);
  end

endmodule

@@ sv/tcvc_order.sv @@
// Stable compaction of both vertex lists, common vertices first.
module tcvc_order #(
  parameter int IDX_W = tcvc_pkg::INDEX_BITS_DEF
) (
  input  logic [IDX_W-1:0]      a_i  [tcvc_pkg::NUM_VERT],
  input  logic [IDX_W-1:0]      b_i  [tcvc_pkg::NUM_VERT],
  input  tcvc_pkg::tcvc_match_t match_i,
  output logic [IDX_W-1:0]      ao_o [tcvc_pkg::NUM_VERT],
  output logic [IDX_W-1:0]      bo_o [tcvc_pkg::NUM_VERT]
);

  logic [tcvc_pkg::SLOT_BITS-1:0] dst_a [tcvc_pkg::NUM_VERT];
  logic [tcvc_pkg::SLOT_BITS-1:0] dst_b [tcvc_pkg::NUM_VERT];
  logic [tcvc_pkg::NA_BITS-1:0]   pa;
  logic [tcvc_pkg::NA_BITS-1:0]   pb;
  logic [IDX_W-1:0]               ac   [tcvc_pkg::NUM_VERT];
  logic [IDX_W-1:0]               bc   [tcvc_pkg::NUM_VERT];

  // Destination slot of every source vertex.
  always_comb begin
    pa = '0;
    pb = match_i.na;
    for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
      dst_a[i] = '0;
      dst_b[i] = '0;
    end
    for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
      if (match_i.ca[i]) begin
        dst_a[i] = pa[tcvc_pkg::SLOT_BITS-1:0];
        pa       = pa + 1'b1;
      end
    end
    for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
      if (!match_i.ca[i]) begin
        dst_a[i] = pa[tcvc_pkg::SLOT_BITS-1:0];
        pa       = pa + 1'b1;
      end
      if (!match_i.cb[i]) begin
        dst_b[i] = pb[tcvc_pkg::SLOT_BITS-1:0];
        pb       = pb + 1'b1;
      end
    end
  end

  // Gather by slot; B opens with the common vertices of A.
  always_comb begin
    for (int s = 0; s < tcvc_pkg::NUM_VERT; s++) begin
      ac[s] = '0;
      bc[s] = '0;
      for (int i = 0; i < tcvc_pkg::NUM_VERT; i++) begin
        if (dst_a[i] == tcvc_pkg::SLOT_BITS'(s)) begin
          ac[s] = ac[s] | a_i[i];
        end
        if (!match_i.cb[i] && (dst_b[i] == tcvc_pkg::SLOT_BITS'(s))) begin
          bc[s] = bc[s] | b_i[i];
        end
      end
      if (tcvc_pkg::NA_BITS'(s) < match_i.na) begin
        bc[s] = ac[s];
      end
    end
  end

  // Pass both lists through when no consistent order exists.
  always_comb begin
    for (int s = 0; s < tcvc_pkg::NUM_VERT; s++) begin
      ao_o[s] = match_i.mismatch ? a_i[s] : ac[s];
      bo_o[s] = match_i.mismatch ? b_i[s] : bc[s];
    end
  end

endmodule

@@ sv/tet_common_vertex_compare.sv @@
// Top level of the tetrahedron common-vertex comparator.

// Takes the four vertex indices of tetrahedra A and B plus a same-mesh flag,
// counts equal index pairs over all sixteen combinations and returns both
// lists reordered stably, common vertices of A first in both, then each
// list's own remaining vertices. With the flag clear the count is zero and
// the lists pass through; when the flagged slot counts of A and B differ
// (duplicate indices) order_mismatch is set, the count stays true and the
// lists pass through. Indices are compared on their low INDEX_BITS bits
// (at most 24), and results carry those bits only. One word is accepted
// every cycle while in_ready is high; its result is offered once it has
// crossed the comparator array and reorder network from the input register
// into the result register, and can leave at the next edge at the earliest.
// The input side keeps accepting while a result waits until the input
// register also holds a word; from then on it accepts only in cycles
// where the result register drains.
module tet_common_vertex_compare #(
  parameter int INDEX_BITS = tcvc_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_same_mesh,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_a_vertex_0,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_a_vertex_1,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_a_vertex_2,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_a_vertex_3,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_b_vertex_0,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_b_vertex_1,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_b_vertex_2,
  input  logic [tcvc_pkg::FIELD_BITS-1:0] in_b_vertex_3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcvc_pkg::COUNT_BITS-1:0] out_common_count,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_a_order_0,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_a_order_1,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_a_order_2,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_a_order_3,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_b_order_0,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_b_order_1,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_b_order_2,
  output logic [tcvc_pkg::FIELD_BITS-1:0] out_b_order_3,
  output logic                            out_order_mismatch
);

  // Bits that survive the index mask; the ports carry 24 at most.
  localparam int KEEP_BITS = (INDEX_BITS < tcvc_pkg::FIELD_BITS) ?
                             INDEX_BITS : tcvc_pkg::FIELD_BITS;

  // Input register
  logic                 s1_v_r;
  logic                 s1_v_nxt;
  logic                 s1_same_r;
  logic [KEEP_BITS-1:0] s1_a_r [tcvc_pkg::NUM_VERT];
  logic [KEEP_BITS-1:0] s1_b_r [tcvc_pkg::NUM_VERT];

  // Result register
  logic                            out_v_r;
  logic                            out_v_nxt;
  logic [tcvc_pkg::COUNT_BITS-1:0] cnt_r;
  logic                            mism_r;
  logic [KEEP_BITS-1:0]            ao_r [tcvc_pkg::NUM_VERT];
  logic [KEEP_BITS-1:0]            bo_r [tcvc_pkg::NUM_VERT];

  // Between the registers
  logic                            s2_ready;
  logic [tcvc_pkg::COUNT_BITS-1:0] cnt;
  tcvc_pkg::tcvc_match_t           match;
  logic [KEEP_BITS-1:0]            ao [tcvc_pkg::NUM_VERT];
  logic [KEEP_BITS-1:0]            bo [tcvc_pkg::NUM_VERT];

  // Result register frees when empty or drained this cycle.
  assign s2_ready = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s2_ready;

  assign s1_v_nxt  = (in_valid && in_ready) || (s1_v_r && !s2_ready);
  assign out_v_nxt = (s1_v_r && s2_ready) || (out_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Load the input word, masked to the compared index bits.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_same_r <= in_same_mesh;
      s1_a_r[0] <= in_a_vertex_0[KEEP_BITS-1:0];
      s1_a_r[1] <= in_a_vertex_1[KEEP_BITS-1:0];
      s1_a_r[2] <= in_a_vertex_2[KEEP_BITS-1:0];
      s1_a_r[3] <= in_a_vertex_3[KEEP_BITS-1:0];
      s1_b_r[0] <= in_b_vertex_0[KEEP_BITS-1:0];
      s1_b_r[1] <= in_b_vertex_1[KEEP_BITS-1:0];
      s1_b_r[2] <= in_b_vertex_2[KEEP_BITS-1:0];
      s1_b_r[3] <= in_b_vertex_3[KEEP_BITS-1:0];
    end
  end

  tcvc_match #(
    .IDX_W(KEEP_BITS)
  ) u_match (
    .same_mesh_i(s1_same_r),
    .a_i        (s1_a_r),
    .b_i        (s1_b_r),
    .count_o    (cnt),
    .match_o    (match)
  );

  tcvc_order #(
    .IDX_W(KEEP_BITS)
  ) u_order (
    .a_i    (s1_a_r),
    .b_i    (s1_b_r),
    .match_i(match),
    .ao_o   (ao),
    .bo_o   (bo)
  );

  // Advance the finished word into the result register.
  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      cnt_r  <= cnt;
      mism_r <= match.mismatch;
      ao_r   <= ao;
      bo_r   <= bo;
    end
  end

  assign out_valid          = out_v_r;
  assign out_common_count   = cnt_r;
  assign out_order_mismatch = mism_r;
  assign out_a_order_0      = tcvc_pkg::FIELD_BITS'(ao_r[0]);
  assign out_a_order_1      = tcvc_pkg::FIELD_BITS'(ao_r[1]);
  assign out_a_order_2      = tcvc_pkg::FIELD_BITS'(ao_r[2]);
  assign out_a_order_3      = tcvc_pkg::FIELD_BITS'(ao_r[3]);
  assign out_b_order_0      = tcvc_pkg::FIELD_BITS'(bo_r[0]);
  assign out_b_order_1      = tcvc_pkg::FIELD_BITS'(bo_r[1]);
  assign out_b_order_2      = tcvc_pkg::FIELD_BITS'(bo_r[2]);
  assign out_b_order_3      = tcvc_pkg::FIELD_BITS'(bo_r[3]);

  // A slot-count mismatch needs at least one equal pair.
  a_mism_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && mism_r |-> cnt_r != '0)
    else $error("mismatch flagged with zero common pairs");

  // Sixteen pairs at most.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> cnt_r <= tcvc_pkg::COUNT_BITS'(16))
    else $error("common count above sixteen");

  // Different meshes give an empty result.
  a_other_mesh: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_ready && !s1_same_r |=> cnt_r == '0 && !mism_r)
    else $error("different meshes produced common pairs");

  // An empty result register never blocks the input side.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled with result register empty");

endmodule
